### hw/rtl/esd_pkg.sv
// Shared types and constants of the escape sequence decoder.
`default_nettype none

package esd_pkg;

    // Characters that the decoder tests for or produces
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Most bytes that one input transaction can produce
    localparam int unsigned GRP_BYTES = 3;

    // Depth of the group queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    // Bytes produced by one input transaction
    typedef struct packed {
        logic [GRP_BYTES-1:0][7:0] data;   // data[0] goes out first
        logic [1:0]                count;  // 1 to 3 bytes valid
        logic                      eos;    // last byte of the group ends the string
    } t_group;

endpackage

`default_nettype wire

### hw/rtl/esd_in_if.sv
// Input channel: escaped bytes with a last-byte mark.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/esd_out_if.sv
// Output channel: decoded bytes with an end-of-string mark.
`default_nettype none

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_string;

    modport source (output valid, output out_byte, output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### hw/rtl/esd_front.sv
// Front end: accepts input bytes, tracks escape state and builds output groups.
`default_nettype none

module esd_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    esd_in_if.sink         i_in,
    output esd_pkg::t_group o_grp,
    output logic           o_grp_valid,
    input  wire logic      i_grp_ready
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BACK = 3'd1,
        PH_HEX1 = 3'd2,
        PH_HEX2 = 3'd3,
        PH_OCT1 = 3'd4,
        PH_OCT2 = 3'd5
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pv, n_pv;
    logic       r_run, n_run;

    logic [7:0] c;
    logic       last;
    logic       hex_ok;
    logic [3:0] hex_v;
    logic       oct_ok;
    logic       accept;
    t_group     grp;

    // Decode one hex digit: {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            r = {1'b1, ch[3:0]};
        end else if (ch inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, 4'(ch[2:0] + 3'd1) + 4'd8};
        end
        return r;
    endfunction

    assign c      = i_in.in_byte;
    assign last   = i_in.is_last;
    assign {hex_ok, hex_v} = hex_digit(c);
    assign oct_ok = (c inside {[8'h30:8'h37]});

    // Accept whenever the queue has room
    assign i_in.ready = i_grp_ready;
    assign accept     = i_in.valid && i_grp_ready;

    // Work out the bytes and next escape state for the current byte
    always_comb begin
        grp      = '0;
        grp.eos  = last;
        n_phase  = PH_IDLE;
        n_pv     = r_pv;
        n_run    = r_run;
        case (r_phase)
            PH_BACK: begin
                if (c == CH_N) begin
                    grp.data[0] = CH_LF;
                    grp.count   = 2'd1;
                end else if (c == CH_R) begin
                    grp.data[0] = CH_CR;
                    grp.count   = 2'd1;
                end else if (c == CH_T) begin
                    grp.data[0] = CH_TAB;
                    grp.count   = 2'd1;
                end else if (c == CH_BSL) begin
                    grp.data[0] = CH_BSL;
                    grp.count   = 2'd1;
                end else if ((c == CH_X || c inside {[8'h30:8'h33]}) && !last) begin
                    if (c == CH_X) begin
                        n_phase = PH_HEX1;
                    end else begin
                        n_pv    = {6'd0, c[1:0]};
                        n_run   = 1'b1;
                        n_phase = PH_OCT1;
                    end
                end else begin
                    grp.data[0] = CH_BSL;
                    grp.data[1] = c;
                    grp.count   = 2'd2;
                end
            end
            PH_HEX1: begin
                if (!hex_ok) begin
                    // Pass the escape through and rescan this byte
                    grp.data[0] = CH_BSL;
                    grp.data[1] = CH_X;
                    if (c == CH_BSL && !last) begin
                        grp.count = 2'd2;
                        n_phase   = PH_BACK;
                    end else begin
                        grp.data[2] = c;
                        grp.count   = 2'd3;
                    end
                end else if (last) begin
                    grp.data[0] = CH_BSL;
                    grp.data[1] = CH_X;
                    grp.data[2] = c;
                    grp.count   = 2'd3;
                end else begin
                    n_pv    = {4'd0, hex_v};
                    n_phase = PH_HEX2;
                end
            end
            PH_HEX2: begin
                n_pv        = hex_ok ? {r_pv[3:0], hex_v} : r_pv;
                grp.data[0] = n_pv;
                grp.count   = 2'd1;
            end
            PH_OCT1: begin
                if (last) begin
                    grp.data[0] = CH_BSL;
                    grp.data[1] = CH_ZERO | {6'd0, r_pv[1:0]};
                    grp.data[2] = c;
                    grp.count   = 2'd3;
                end else begin
                    if (r_run && oct_ok) begin
                        n_pv = {r_pv[4:0], c[2:0]};
                    end else begin
                        n_run = 1'b0;
                    end
                    n_phase = PH_OCT2;
                end
            end
            PH_OCT2: begin
                n_pv        = (r_run && oct_ok) ? {r_pv[4:0], c[2:0]} : r_pv;
                n_run       = 1'b0;
                grp.data[0] = n_pv;
                grp.count   = 2'd1;
            end
            default: begin
                if (c == CH_BSL && !last) begin
                    n_phase = PH_BACK;
                end else begin
                    grp.data[0] = c;
                    grp.count   = 2'd1;
                end
            end
        endcase
        // Drop any open escape at the end of the string
        if (last) begin
            n_phase = PH_IDLE;
            n_run   = 1'b0;
        end
    end

    // Push only groups that carry bytes
    assign o_grp       = grp;
    assign o_grp_valid = accept && (grp.count != 2'd0);

    // Hold escape state, advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pv    <= 8'd0;
            r_run   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pv    <= n_pv;
            r_run   <= n_run;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/esd_queue.sv
// Short queue of output groups between front and back.
`default_nettype none

module esd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire esd_pkg::t_group i_wr_grp,
    input  wire logic            i_wr_valid,
    output logic                 o_wr_ready,
    output esd_pkg::t_group      o_rd_grp,
    output logic                 o_rd_valid,
    input  wire logic            i_rd_ready
);
    import esd_pkg::*;

    t_group          r_mem [QDEPTH];
    logic [QAW-1:0]  r_wptr;
    logic [QAW-1:0]  r_rptr;
    logic [QAW:0]    r_cnt;
    logic            push;
    logic            pop;

    assign o_wr_ready = (r_cnt != (QAW+1)'(QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_grp   = r_mem[r_rptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_ready && o_rd_valid;

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_wr_grp;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QAW'(QDEPTH - 1)) ? '0 : QAW'(r_wptr + 1'b1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == QAW'(QDEPTH - 1)) ? '0 : QAW'(r_rptr + 1'b1);
            end
            if (push && !pop) begin
                r_cnt <= (QAW+1)'(r_cnt + 1'b1);
            end else if (pop && !push) begin
                r_cnt <= (QAW+1)'(r_cnt - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/esd_back.sv
// Back end: sends the bytes of each group out one per cycle while o_out.ready is high.
`default_nettype none

module esd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire esd_pkg::t_group i_grp,
    input  wire logic            i_grp_valid,
    output logic                 o_grp_ready,
    esd_out_if.source            o_out
);
    import esd_pkg::*;

    t_group     r_grp;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last_of_grp;
    logic       sent;
    logic       load;

    assign last_of_grp = (r_idx == 2'(r_grp.count - 2'd1));
    assign sent        = r_valid && o_out.ready;
    assign o_grp_ready = !r_valid || (sent && last_of_grp);
    assign load        = o_grp_ready && i_grp_valid;

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_grp.data[r_idx];
    assign o_out.end_of_string = r_grp.eos && last_of_grp;

    // Load the next group, or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (sent) begin
            if (last_of_grp) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= 2'(r_idx + 2'd1);
            end
        end
    end

    // Group payload needs no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_grp;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/escape_sequence_decoder.sv
// Escape sequence decoder: top level joining front end, group queue and back end.
//
// Usage:
//   i_in carries the escaped string one byte per transaction, with is_last set
//   on its final byte. o_out carries the decoded bytes, with end_of_string set
//   on the final decoded byte of each string (when the string decodes to any).
//   Each input transaction yields zero to three output bytes as one group.
// Path: each group is written into the queue and then loaded into the back
//   end's group register before its first byte is presented on o_out.
// Throughput: with o_out.ready high, one input byte per cycle while each
//   produces at most one output byte; o_out sends one byte per cycle, so a
//   group of two or three bytes holds the output until all of its bytes are
//   sent. A four-group queue between the front end and the output stage
//   absorbs these bursts; i_in.ready drops only while that queue is full.
// Reset: synchronous, active low; the escape state returns to idle, the queue
//   empties and o_out.valid goes low.
// Stall: while o_out.ready is low the current byte holds, the queue fills and
//   then i_in.ready falls; nothing is lost or repeated.
`default_nettype none

module escape_sequence_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);
    import esd_pkg::*;

    t_group f_grp;
    logic   f_valid;
    logic   f_ready;
    t_group q_grp;
    logic   q_valid;
    logic   q_ready;

    // Classify input bytes into groups
    esd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_grp       (f_grp),
        .o_grp_valid (f_valid),
        .i_grp_ready (f_ready)
    );

    // Buffer groups between the two sides
    esd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_grp   (f_grp),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .o_rd_grp   (q_grp),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready)
    );

    // Serialize groups onto the output channel
    esd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (q_grp),
        .i_grp_valid (q_valid),
        .o_grp_ready (q_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the escape sequence decoder.
`default_nettype none

module testbench;
    import esd_pkg::*;

    // Escape scan states of the byte-level decode
    typedef enum logic [2:0] {
        ESC_IDLE      = 3'd0,
        ESC_AFTER_BSL = 3'd1,
        ESC_HEX_WAIT1 = 3'd2,
        ESC_HEX_WAIT2 = 3'd3,
        ESC_OCT_WAIT1 = 3'd4,
        ESC_OCT_WAIT2 = 3'd5
    } t_esc_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_dec_byte;

    // Digit bounds used by the hex and octal decode
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_F = 8'h66;

    localparam string HEX_CHARS    = "0123456789abcdefABCDEF";
    localparam string SIMPLE_CODES = "nrt\\";

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    esd_in_if  in_ch ();
    esd_out_if out_ch ();

    escape_sequence_decoder i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Decode state, mirrors the block after reset
    t_esc_phase esc_phase   = ESC_IDLE;
    logic [7:0] held_lead   = 8'h00;
    logic [8:0] partial     = 9'd0;
    logic       run_open    = 1'b0;

    logic [7:0] out_group[$];
    t_dec_byte  expected_bytes[$];
    logic [7:0] text_buf[$];

    bit src_stalls  = 1'b0;
    bit sink_stalls = 1'b0;
    int hold_requests = 0;
    int holds_served  = 0;

    int items_sent    = 0;
    int strings_sent  = 0;
    int bytes_checked = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    // Clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_LOW_A && c <= CH_LOW_F)
            return int'(c) - int'(CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c) - int'(CH_UP_A) + 10;
        return -1;
    endfunction

    function automatic bit is_octal(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    // Append one decoded byte to the group of the current step
    function automatic void emit_byte(input logic [7:0] v);
        out_group.insert(out_group.size(), v);
    endfunction

    // Append one char to the string being built
    function automatic void add_char(input logic [7:0] v);
        text_buf.insert(text_buf.size(), v);
    endfunction

    // Start an escape or pass the byte through
    function automatic void scan_from_idle(input logic [7:0] c, input logic last);
        if (c == CH_BSL && !last)
            esc_phase = ESC_AFTER_BSL;
        else
            emit_byte(c);
    endfunction

    // Advance the decode by one accepted byte and queue the bytes it yields
    task automatic decode_byte(input logic [7:0] c, input logic last);
        t_esc_phase ph;
        int         hv;
        t_dec_byte  b;
        ph = esc_phase;
        esc_phase = ESC_IDLE;
        case (ph)
            ESC_AFTER_BSL: begin
                if (c == CH_N)
                    emit_byte(CH_LF);
                else if (c == CH_R)
                    emit_byte(CH_CR);
                else if (c == CH_T)
                    emit_byte(CH_TAB);
                else if (c == CH_BSL)
                    emit_byte(CH_BSL);
                else if ((c == CH_X || (c >= CH_ZERO && c <= CH_THREE)) && !last) begin
                    held_lead = c;
                    if (c == CH_X) begin
                        esc_phase = ESC_HEX_WAIT1;
                    end else begin
                        partial   = {7'd0, c[1:0]};
                        run_open  = 1'b1;
                        esc_phase = ESC_OCT_WAIT1;
                    end
                end else begin
                    emit_byte(CH_BSL);
                    emit_byte(c);
                end
            end
            ESC_HEX_WAIT1: begin
                hv = hex_value(c);
                if (hv < 0) begin
                    emit_byte(CH_BSL);
                    emit_byte(CH_X);
                    scan_from_idle(c, last);
                end else if (last) begin
                    emit_byte(CH_BSL);
                    emit_byte(CH_X);
                    emit_byte(c);
                end else begin
                    partial   = {5'd0, hv[3:0]};
                    esc_phase = ESC_HEX_WAIT2;
                end
            end
            ESC_HEX_WAIT2: begin
                hv = hex_value(c);
                if (hv >= 0)
                    partial = {1'b0, partial[3:0], hv[3:0]};
                emit_byte(partial[7:0]);
            end
            ESC_OCT_WAIT1: begin
                if (last) begin
                    emit_byte(CH_BSL);
                    emit_byte(held_lead);
                    emit_byte(c);
                end else begin
                    if (run_open && is_octal(c))
                        partial = {partial[5:0], c[2:0]};
                    else
                        run_open = 1'b0;
                    esc_phase = ESC_OCT_WAIT2;
                end
            end
            ESC_OCT_WAIT2: begin
                if (run_open && is_octal(c))
                    partial = {partial[5:0], c[2:0]};
                run_open = 1'b0;
                emit_byte(partial[7:0]);
            end
            default: scan_from_idle(c, last);
        endcase

        if (last) begin
            esc_phase = ESC_IDLE;
            run_open  = 1'b0;
        end
        foreach (out_group[i]) begin
            b.data = out_group[i];
            b.eos  = last && (i == out_group.size() - 1);
            expected_bytes.insert(expected_bytes.size(), b);
        end
        out_group.delete();
    endtask

    // Offer one byte, hold it until the transaction completes, then predict
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap(src_stalls);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.is_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        decode_byte(c, last);
    endtask

    // Send the buffered string, marking its final byte
    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        strings_sent++;
        text_buf.delete();
    endtask

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] hex_char();
        return HEX_CHARS[$urandom_range(HEX_CHARS.len() - 1)];
    endfunction

    function automatic logic [7:0] octal_char();
        return 8'(CH_ZERO + $urandom_range(7));
    endfunction

    // Build a string of mostly well-formed escapes with random content
    task automatic build_random_text();
        int tokens;
        int kind;
        int keep;
        tokens = $urandom_range(6, 1);
        repeat (tokens) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                add_char(random_byte());
            end else if (kind < 45) begin
                add_char(CH_BSL);
                add_char(SIMPLE_CODES[$urandom_range(3)]);
            end else if (kind < 65) begin
                add_char(CH_BSL);
                add_char(CH_X);
                add_char(($urandom_range(9) == 0) ? random_byte() : hex_char());
                add_char(($urandom_range(4) == 0) ? random_byte() : hex_char());
            end else if (kind < 85) begin
                add_char(CH_BSL);
                add_char(8'(CH_ZERO + $urandom_range(3)));
                add_char(($urandom_range(3) == 0) ? random_byte() : octal_char());
                add_char(($urandom_range(3) == 0) ? random_byte() : octal_char());
            end else begin
                add_char(CH_BSL);
                add_char(random_byte());
            end
        end
        // Cut the string short now and then, often inside an escape
        if ($urandom_range(6) == 0 && text_buf.size() > 1) begin
            keep = $urandom_range(text_buf.size() - 1, 1);
            while (text_buf.size() > keep)
                void'(text_buf.pop_back());
        end
    endtask

    // Pause the input until every expected byte has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d, output byte %0d: %s got %h want %h",
                     cycle_count, bytes_checked, what, got, want);
    endtask

    // Output side: random stalls plus long holds on request
    initial begin : sink_side
        int idle_left;
        idle_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (holds_served != hold_requests) begin
                holds_served++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (idle_left > 0) begin
                idle_left--;
                out_ch.ready <= 1'b0;
                @(posedge clk);
            end else begin
                idle_left = pick_gap(sink_stalls);
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each output transaction with the oldest expected byte
    always @(posedge clk) begin : check_output
        t_dec_byte oldest;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", out_ch.out_byte, 8'h00);
            end else begin
                oldest = expected_bytes.pop_front();
                if (out_ch.out_byte !== oldest.data)
                    report_mismatch("out_byte", out_ch.out_byte, oldest.data);
                if (out_ch.end_of_string !== oldest.eos)
                    report_mismatch("end_of_string", 8'(out_ch.end_of_string),
                                    8'(oldest.eos));
            end
            bytes_checked++;
        end
    end

    // Single-char escapes, an unknown escape with extreme bytes
    task automatic test_simple_escapes();
        src_stalls = 1'b1;
        sink_stalls <= 1'b1;
        load_text("\\n\\t\\r\\\\");
        add_char(CH_BSL);
        add_char(8'hFF);
        add_char(8'h00);
        send_text();
        wait_drained();
    endtask

    // Both hex digit cases, a bad second digit, a bad first digit at string end
    task automatic test_hex_escapes();
        load_text("\\xaF\\x9z");
        send_text();
        load_text("\\x\\");
        send_text();
        wait_drained();
    endtask

    // Full octal run, a broken run, and an octal escape cut short
    task automatic test_octal_escapes();
        load_text("\\377\\08z");
        send_text();
        load_text("\\2");
        send_text();
        wait_drained();
    endtask

    task automatic test_random_strings(input int target);
        int start;
        start = items_sent;
        src_stalls = 1'b1;
        sink_stalls <= 1'b1;
        while (items_sent - start < target) begin
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    // Hold the output long enough that the block backs up into its input
    task automatic test_output_hold(input int target);
        int start;
        start = items_sent;
        src_stalls = 1'b0;
        sink_stalls <= 1'b0;
        hold_requests <= hold_requests + 1;
        while (items_sent - start < target) begin
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    task automatic test_full_rate(input int target);
        int start;
        start = items_sent;
        src_stalls = 1'b0;
        sink_stalls <= 1'b0;
        while (items_sent - start < target) begin
            build_random_text();
            send_text();
        end
        wait_drained();
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.is_last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_simple_escapes();
        test_hex_escapes();
        test_octal_escapes();
        test_random_strings(260);
        test_output_hold(60);
        test_full_rate(70);

        $display("ran %0d input bytes in %0d strings over %0d cycles",
                 items_sent, strings_sent, cycle_count);
        $display("checked %0d decoded bytes, %0d long output holds, %0d mismatches",
                 bytes_checked, holds_served, mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
